FILE: rtl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types and constants for the hostname syntax checker.
// ----------------------------------------------------------------------------
package hsc_pkg;

   // Field and state widths
   localparam int CH_W         = 8;
   localparam int LABEL_LIM_W  = 6;
   localparam int NAME_LIM_W   = 8;
   localparam int LABEL_CNT_W  = 7;
   localparam int TOTAL_CNT_W  = 9;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 8;

   // Reset values of the limit registers
   localparam logic [LABEL_LIM_W-1:0] LABEL_LIM_RST = 6'd63;
   localparam logic [NAME_LIM_W-1:0]  NAME_LIM_RST  = 8'd255;

   // Counter ceilings
   localparam logic [LABEL_CNT_W-1:0] LABEL_CNT_MAX = '1;
   localparam logic [TOTAL_CNT_W-1:0] TOTAL_CNT_MAX = '1;

   // Special bytes
   localparam logic [CH_W-1:0] CH_NUL        = 8'h00;
   localparam logic [CH_W-1:0] CH_DOT        = 8'h2E;
   localparam logic [CH_W-1:0] CH_HYPHEN     = 8'h2D;
   localparam logic [CH_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CH_W-1:0] CH_DIGIT_LO   = 8'h30;
   localparam logic [CH_W-1:0] CH_DIGIT_HI   = 8'h39;
   localparam logic [CH_W-1:0] CH_UPPER_LO   = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_HI   = 8'h5A;
   localparam logic [CH_W-1:0] CH_LOWER_LO   = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_HI   = 8'h7A;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LABEL_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NAME_LIMIT  = 1'd1;

   // Status codes
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_LABEL_LONG = 3'd2,
      ST_BAD_DOT    = 3'd3,
      ST_BAD_HYPHEN = 3'd4,
      ST_BAD_CHAR   = 3'd5,
      ST_NUMERIC    = 3'd6,
      ST_TOO_LONG   = 3'd7
   } status_type;

   // Limit settings handed to the tracker
   typedef struct packed {
      logic [LABEL_LIM_W-1:0] label_limit;
      logic [NAME_LIM_W-1:0]  name_limit;
   } cfg_type;

   // One finished result
   typedef struct packed {
      status_type status;
      logic       name_ok;
   } result_type;

endpackage

FILE: rtl/hsc_csr.sv
// ----------------------------------------------------------------------------
// hsc_csr
// Limit registers, written through a plain write port.
// ----------------------------------------------------------------------------
module hsc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [hsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hsc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output hsc_pkg::cfg_type             cfg
);
   import hsc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LABEL_LIMIT: cfg_in.label_limit = csr_wdata[LABEL_LIM_W-1:0];
            CSR_NAME_LIMIT:  cfg_in.name_limit  = csr_wdata[NAME_LIM_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.label_limit <= LABEL_LIM_RST;
         cfg_ff.name_limit  <= NAME_LIM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/hsc_track.sv
// ----------------------------------------------------------------------------
// hsc_track
// Per-name scan state: counters, delimiter flags and the latched error.
// Produces one status when the terminating zero byte is taken.
// ----------------------------------------------------------------------------
module hsc_track (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic [hsc_pkg::CH_W-1:0] ch,
   input  hsc_pkg::cfg_type         cfg,
   output logic                     push,
   output hsc_pkg::result_type      result
);
   import hsc_pkg::*;

   logic [LABEL_CNT_W-1:0] label_cnt_ff, label_cnt_in;
   logic [TOTAL_CNT_W-1:0] total_cnt_ff, total_cnt_in;
   logic                   nondigit_ff, nondigit_in;
   logic                   prev_hyp_ff, prev_hyp_in;
   logic                   prev_dot_ff, prev_dot_in;
   status_type             err_ff, err_in;

   logic                   is_end;
   logic                   is_digit, is_letter, is_label_ch;
   logic [LABEL_CNT_W-1:0] label_inc;
   logic [TOTAL_CNT_W-1:0] total_inc;
   status_type             final_st;

   // Classify the byte
   assign is_end      = (ch == CH_NUL);
   assign is_digit    = (ch >= CH_DIGIT_LO) && (ch <= CH_DIGIT_HI);
   assign is_letter   = ((ch >= CH_UPPER_LO) && (ch <= CH_UPPER_HI)) ||
                        ((ch >= CH_LOWER_LO) && (ch <= CH_LOWER_HI));
   assign is_label_ch = is_digit || is_letter || (ch == CH_UNDERSCORE);

   // Saturating increments
   assign label_inc = (label_cnt_ff == LABEL_CNT_MAX) ? label_cnt_ff
                                                      : label_cnt_ff + 1'b1;
   assign total_inc = (total_cnt_ff == TOTAL_CNT_MAX) ? total_cnt_ff
                                                      : total_cnt_ff + 1'b1;

   // Pick the status for the end of the name
   always_comb begin
      if (err_ff != ST_OK)
         final_st = err_ff;
      else if (total_cnt_ff == '0)
         final_st = ST_EMPTY;
      else if (prev_hyp_ff)
         final_st = ST_BAD_HYPHEN;
      else if (prev_dot_ff)
         final_st = ST_BAD_DOT;
      else if (!nondigit_ff)
         final_st = ST_NUMERIC;
      else if (total_cnt_ff > {1'b0, cfg.name_limit})
         final_st = ST_TOO_LONG;
      else
         final_st = ST_OK;
   end

   // Advance the scan state by one byte
   always_comb begin
      label_cnt_in = label_cnt_ff;
      total_cnt_in = total_cnt_ff;
      nondigit_in  = nondigit_ff;
      prev_hyp_in  = prev_hyp_ff;
      prev_dot_in  = prev_dot_ff;
      err_in       = err_ff;
      if (take && is_end) begin
         // clear for the next name
         label_cnt_in = '0;
         total_cnt_in = '0;
         nondigit_in  = 1'b0;
         prev_hyp_in  = 1'b0;
         prev_dot_in  = 1'b0;
         err_in       = ST_OK;
      end else if (take && (err_ff == ST_OK)) begin
         total_cnt_in = total_inc;
         prev_hyp_in  = 1'b0;
         if (prev_hyp_ff && (ch == CH_DOT)) begin
            err_in = ST_BAD_HYPHEN;
         end else if (is_label_ch) begin
            label_cnt_in = label_inc;
            prev_dot_in  = 1'b0;
            if (label_inc > {1'b0, cfg.label_limit})
               err_in = ST_LABEL_LONG;
            else if (!is_digit)
               nondigit_in = 1'b1;
         end else if (ch == CH_DOT) begin
            if (label_cnt_ff == '0) begin
               err_in = ST_BAD_DOT;
            end else begin
               label_cnt_in = '0;
               prev_dot_in  = 1'b1;
            end
         end else if (ch == CH_HYPHEN) begin
            label_cnt_in = label_inc;
            prev_dot_in  = 1'b0;
            if (label_inc == LABEL_CNT_W'(1))
               err_in = ST_BAD_HYPHEN;
            else
               prev_hyp_in = 1'b1;
         end else begin
            err_in = ST_BAD_CHAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_cnt_ff <= '0;
         total_cnt_ff <= '0;
         nondigit_ff  <= 1'b0;
         prev_hyp_ff  <= 1'b0;
         prev_dot_ff  <= 1'b0;
         err_ff       <= ST_OK;
      end else begin
         label_cnt_ff <= label_cnt_in;
         total_cnt_ff <= total_cnt_in;
         nondigit_ff  <= nondigit_in;
         prev_hyp_ff  <= prev_hyp_in;
         prev_dot_ff  <= prev_dot_in;
         err_ff       <= err_in;
      end
   end

   assign push           = take && is_end;
   assign result.status  = final_st;
   assign result.name_ok = (final_st == ST_OK);

   // A latched error holds until the name ends
   a_err_holds: assert property (@(posedge clock) disable iff (reset)
      ((err_ff != ST_OK) && !(take && is_end)) |=> (err_ff == $past(err_ff)))
      else $error("latched error changed before the terminator");

   // Every name starts from a clean state
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      push |=> ((total_cnt_ff == '0) && (label_cnt_ff == '0) && (err_ff == ST_OK)))
      else $error("state not cleared after terminator");

   // Bytes after an error leave the total count alone
   a_total_frozen: assert property (@(posedge clock) disable iff (reset)
      ((err_ff != ST_OK) && !(take && is_end)) |=> $stable(total_cnt_ff))
      else $error("total count moved after an error");

   // A trailing delimiter never pairs with a nonempty label after a dot
   a_dot_clears_label: assert property (@(posedge clock) disable iff (reset)
      prev_dot_ff |-> (label_cnt_ff == '0))
      else $error("label count nonzero right after a dot");

endmodule

FILE: rtl/hsc_out.sv
// ----------------------------------------------------------------------------
// hsc_out
// Result register with valid/ready handshake toward the receiver.
// ----------------------------------------------------------------------------
module hsc_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hsc_pkg::result_type result,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hsc_pkg::result_type rsp_data
);
   import hsc_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // Free when empty or draining this cycle
   assign room = !valid_ff || rsp_ready;

   // Load on push, drop on take
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (push) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // A push only lands in a free slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("result pushed into a full register");

   // The ok flag always agrees with the status
   a_ok_matches: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.name_ok == (data_ff.status == ST_OK)))
      else $error("name_ok disagrees with status");

   // A push always shows up as a pending result
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push |=> valid_ff)
      else $error("pushed result not visible");

endmodule

FILE: rtl/hostname_syntax_checker_top.sv
// ----------------------------------------------------------------------------
// hostname_syntax_checker_top
// Hostname syntax checker: scans a name byte by byte and reports one status.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_ch carry one name byte per item; a zero byte
//   ends the name. Nonzero bytes produce no result. The zero byte produces
//   one result item on rsp_valid/rsp_ready with rsp_status and rsp_name_ok.
//   The limits are written through csr_we/csr_index/csr_wdata (index 0 is
//   the label limit, index 1 the name limit) while the block is idle.
// Latency and throughput:
//   One byte per cycle while req_ready is high. The result of a zero byte is
//   valid on the cycle after acceptance, straight from the result register.
// Stall:
//   The single result register sets the rate: while a result waits and the
//   receiver holds rsp_ready low, req_ready is low. When rsp_ready is high a
//   new byte is taken in the same cycle the old result leaves.
// Reset:
//   Synchronous, active high. Clears the scan state and the result valid flag
//   and returns the limits to 63 and 255.
// ----------------------------------------------------------------------------
module hostname_syntax_checker_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [hsc_pkg::CH_W-1:0]       req_ch,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic                           rsp_name_ok,
   input  logic                           csr_we,
   input  logic [hsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hsc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hsc_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_data;
   logic       push;
   logic       room;
   logic       take;

   // Limit registers
   hsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Accept a byte whenever the result register can take a result
   assign req_ready = room;
   assign take      = req_valid && room;

   // Scan state
   hsc_track u_track (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .ch     (req_ch),
      .cfg    (cfg),
      .push   (push),
      .result (result)
   );

   // Result register
   hsc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .result    (result),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_status  = rsp_data.status;
   assign rsp_name_ok = rsp_data.name_ok;

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hostname syntax checker.
// ----------------------------------------------------------------------------
// Feeds hostnames one byte per item, each closed by a zero byte, and keeps a
// bit-level copy of the scan state to predict the status of every name.
// A short directed pass hits each status and the delimiter corner cases.
// A long hyphen run then pushes the label counter into saturation. Random
// phases follow, each under its own pair of limits: mostly well-formed names
// with random content, plus broken names and byte noise. The sender idles in
// bursts, and the receiver stalls on a pattern of its own. Once, the receiver
// holds off for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hsc_pkg::*;

   localparam int HOLD_CYCLES = 300;

   // Predicts the status of each name from the bytes the block accepts
   class hostname_scoreboard;
      logic [LABEL_LIM_W-1:0] label_lim;
      logic [NAME_LIM_W-1:0]  name_lim;
      logic [LABEL_CNT_W-1:0] label_cnt;
      logic [TOTAL_CNT_W-1:0] total_cnt;
      bit                     saw_alpha;
      bit                     prev_hyphen;
      bit                     prev_dot;
      status_type             err;
      result_type             want_q[$];
      int                     errors;

      function new();
         label_lim = LABEL_LIM_RST;
         name_lim  = NAME_LIM_RST;
         errors    = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         label_cnt   = '0;
         total_cnt   = '0;
         saw_alpha   = 1'b0;
         prev_hyphen = 1'b0;
         prev_dot    = 1'b0;
         err         = ST_OK;
      endfunction

      function bit is_digit(logic [CH_W-1:0] c);
         return c >= CH_DIGIT_LO && c <= CH_DIGIT_HI;
      endfunction

      function int pending();
         return want_q.size();
      endfunction

      // Advance the scan by one accepted byte; a zero byte yields a status
      function void note_item(logic [CH_W-1:0] c);
         bit         was_hyphen;
         bit         is_label;
         result_type want;
         if (c != CH_NUL) begin
            if (err != ST_OK)
               return;
            was_hyphen = prev_hyphen;
            is_label   = is_digit(c) || c == CH_UNDERSCORE ||
                         (c >= CH_UPPER_LO && c <= CH_UPPER_HI) ||
                         (c >= CH_LOWER_LO && c <= CH_LOWER_HI);
            if (total_cnt != TOTAL_CNT_MAX)
               total_cnt++;
            prev_hyphen = 1'b0;
            if (was_hyphen && c == CH_DOT) begin
               err = ST_BAD_HYPHEN;
            end else if (is_label) begin
               if (label_cnt != LABEL_CNT_MAX)
                  label_cnt++;
               prev_dot = 1'b0;
               if (label_cnt > label_lim)
                  err = ST_LABEL_LONG;
               else if (!is_digit(c))
                  saw_alpha = 1'b1;
            end else if (c == CH_DOT) begin
               if (label_cnt == 0) begin
                  err = ST_BAD_DOT;
               end else begin
                  label_cnt = '0;
                  prev_dot  = 1'b1;
               end
            end else if (c == CH_HYPHEN) begin
               // a hyphen counts toward the label but skips the limit check
               if (label_cnt != LABEL_CNT_MAX)
                  label_cnt++;
               prev_dot = 1'b0;
               if (label_cnt == 1)
                  err = ST_BAD_HYPHEN;
               else
                  prev_hyphen = 1'b1;
            end else begin
               err = ST_BAD_CHAR;
            end
            return;
         end
         // terminator: latched error first, then the end-of-name checks
         if (err != ST_OK)
            want.status = err;
         else if (total_cnt == 0)
            want.status = ST_EMPTY;
         else if (prev_hyphen)
            want.status = ST_BAD_HYPHEN;
         else if (prev_dot)
            want.status = ST_BAD_DOT;
         else if (!saw_alpha)
            want.status = ST_NUMERIC;
         else if (total_cnt > name_lim)
            want.status = ST_TOO_LONG;
         else
            want.status = ST_OK;
         want.name_ok = (want.status == ST_OK);
         want_q.push_back(want);
         clear_scan();
      endfunction

      // Compare one accepted result with the oldest prediction
      function void check_result(logic [2:0] st, logic ok);
         result_type want;
         if (want_q.size() == 0) begin
            $display("%0t ns: result with nothing pending: expected none, actual status %0d",
                     $time, st);
            errors++;
            return;
         end
         want = want_q.pop_front();
         if (st !== want.status) begin
            $display("%0t ns: status mismatch: expected %0d, actual %0d",
                     $time, want.status, st);
            errors++;
         end
         if (ok !== want.name_ok) begin
            $display("%0t ns: name_ok mismatch: expected %0d, actual %0d",
                     $time, want.name_ok, ok);
            errors++;
         end
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [CH_W-1:0]       req_ch      = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [2:0]            rsp_status;
   logic                  rsp_name_ok;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   hostname_scoreboard sb = new();

   logic [CH_W-1:0] name_buf[$];
   int              burst_left = 1;
   bit              no_gaps    = 1'b0;
   bit              hold_req   = 1'b0;
   int              ph_items;
   int              ph_names;

   hostname_syntax_checker_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_ch      (req_ch),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_name_ok (rsp_name_ok),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_status, rsp_name_ok);
         if (req_valid && req_ready)
            sb.note_item(req_ch);
      end
   end

   // Stall the result channel on a rotating pattern, or hold off on request
   initial begin : rsp_stall
      int tick;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            case ((tick / 40) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (tick % 4 == 0);
               default: rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // Hard stop in case the handshakes hang
   initial begin
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // Offer one byte and hold it until accepted; idle between bursts
   task automatic send_byte(input logic [CH_W-1:0] c);
      @(negedge clock);
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock); while (!req_ready);
      ph_items++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
         if (!no_gaps)
            repeat ($urandom_range(0, 6)) begin
               @(negedge clock);
               req_valid <= 1'b0;
            end
      end
   endtask

   // Send the buffered name followed by its terminator
   task automatic send_buf();
      foreach (name_buf[i])
         send_byte(name_buf[i]);
      send_byte(CH_NUL);
      ph_names++;
   endtask

   task automatic send_name(input string s);
      name_buf.delete();
      for (int i = 0; i < s.len(); i++)
         name_buf.push_back(s[i]);
      send_buf();
   endtask

   // Drop valid and wait until every predicted status has come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_LABEL_LIMIT)
         sb.label_lim = data[LABEL_LIM_W-1:0];
      else
         sb.name_lim = data[NAME_LIM_W-1:0];
   endtask

   function automatic logic [CH_W-1:0] label_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 26) return CH_LOWER_LO + CH_W'(r);
      if (r < 52) return CH_UPPER_LO + CH_W'(r - 26);
      if (r < 62) return CH_DIGIT_LO + CH_W'(r - 52);
      return CH_UNDERSCORE;
   endfunction

   function automatic logic [CH_W-1:0] any_char();
      case ($urandom_range(0, 9))
         0: return CH_DOT;
         1: return CH_HYPHEN;
         2, 3, 4, 5: return label_char();
         default: return CH_W'($urandom_range(1, 255));
      endcase
   endfunction

   // Build a random name: mostly well-formed, some broken, some noise
   function automatic void gen_name();
      int kind;
      int lim;
      int hi;
      int len;
      int pos;
      bit numeric;
      name_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 5)
         return;
      if (kind >= 85) begin
         repeat ($urandom_range(1, 8)) name_buf.push_back(any_char());
         return;
      end
      lim     = sb.label_lim;
      hi      = (lim < 1) ? 1 : ((lim < 8) ? lim : 8);
      numeric = ($urandom_range(0, 9) == 0);
      for (int l = $urandom_range(1, 3); l > 0; l--) begin
         if (name_buf.size() != 0)
            name_buf.push_back(CH_DOT);
         if ($urandom_range(0, 9) != 0 || lim == 0)
            len = $urandom_range(1, hi);
         else
            len = $urandom_range(lim, lim + 1);
         for (int i = 0; i < len; i++) begin
            if (i > 0 && i < len - 1 && $urandom_range(0, 5) == 0)
               name_buf.push_back(CH_HYPHEN);
            else if (numeric)
               name_buf.push_back(CH_DIGIT_LO + CH_W'($urandom_range(0, 9)));
            else
               name_buf.push_back(label_char());
         end
      end
      // break some names at a random spot
      if (kind >= 65) begin
         pos = $urandom_range(0, name_buf.size() - 1);
         case ($urandom_range(0, 3))
            0: name_buf[pos] = any_char();
            1: name_buf.push_back($urandom_range(0, 1) ? CH_DOT : CH_HYPHEN);
            2: name_buf.push_front($urandom_range(0, 1) ? CH_DOT : CH_HYPHEN);
            default: begin
               name_buf.insert(pos, CH_DOT);
               name_buf.insert(pos, CH_HYPHEN);
            end
         endcase
      end
   endfunction

   // Random names under one pair of limits, optionally with a long hold-off
   task automatic run_phase(input logic [CSR_DATA_W-1:0] lab,
                            input logic [CSR_DATA_W-1:0] nam,
                            input bit                    with_hold);
      int rush;
      write_csr(CSR_LABEL_LIMIT, lab);
      write_csr(CSR_NAME_LIMIT, nam);
      ph_items = 0;
      ph_names = 0;
      rush     = 0;
      while (ph_items < 32 || ph_names < 5) begin
         if (with_hold && ph_names == 2 && rush == 0) begin
            hold_req = 1'b1;
            no_gaps  = 1'b1;
            rush     = 8;
         end
         gen_name();
         send_buf();
         if (rush > 1) begin
            rush--;
         end else if (rush == 1) begin
            no_gaps = 1'b0;
            rush    = -1;
         end
      end
      wait_idle();
   endtask

   initial begin : main
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every status but the two length errors under the reset limits
      send_name("");
      send_name("a");
      name_buf.delete();
      name_buf.push_back(8'hFF);
      send_buf();
      send_name("-");
      send_name("a-.b");
      send_name("a-");
      send_name(".");
      send_name("a..");
      send_name("a.");
      send_name("09");
      wait_idle();

      // Directed: tight limits for label too long and name too long
      write_csr(CSR_LABEL_LIMIT, 8'd1);
      write_csr(CSR_NAME_LIMIT, 8'd2);
      send_name("ab");
      send_name("a.b");
      wait_idle();

      // Reset-size limits: saturate the label counter with a long hyphen run
      write_csr(CSR_LABEL_LIMIT, 8'd63);
      write_csr(CSR_NAME_LIMIT, 8'd255);
      name_buf.delete();
      name_buf.push_back(CH_LOWER_LO);
      repeat (130) name_buf.push_back(CH_HYPHEN);
      name_buf.push_back(CH_LOWER_LO);
      send_buf();
      wait_idle();

      // Random phases across the range of both limits
      run_phase(8'd63, 8'd255, 1'b1);
      run_phase(8'd1, 8'd255, 1'b0);
      run_phase(8'd5, 8'd20, 1'b0);
      run_phase(8'd0, 8'd0, 1'b0);
      run_phase(8'd63, 8'd1, 1'b0);
      run_phase(CSR_DATA_W'($urandom_range(0, 63)), CSR_DATA_W'($urandom_range(0, 255)), 1'b0);
      run_phase(CSR_DATA_W'($urandom_range(0, 63)), CSR_DATA_W'($urandom_range(0, 255)), 1'b0);

      if (sb.errors == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end
endmodule
